### sv/tvt_pkg.sv
package tvt_pkg;

  typedef logic [2:0] status_t;

  // Result status codes
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_INVALID  = 3'd1;
  localparam status_t ST_PAUSED   = 3'd2;
  localparam status_t ST_NONMONO  = 3'd3;
  localparam status_t ST_OVERFLOW = 3'd4;
  localparam status_t ST_DRIFT    = 3'd5;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned MODE_W    = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SOURCE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_VIRTUAL = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET       = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR        = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIFT    = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GENERATION   = 8'd7;

  // Mode bits
  localparam int unsigned MODE_PAUSE = 0;
  localparam int unsigned MODE_CLAMP = 1;

  typedef struct packed {
    logic [63:0]        base_src;
    logic [63:0]        base_virt;
    logic [63:0]        rate_scale;
    logic signed [63:0] tick_offset;
    logic [63:0]        floor_virt;
    logic [63:0]        drift_limit;
    logic [MODE_W-1:0]  mode_bits;
    logic [63:0]        generation_tag;
  } cfg_t;

  // Word moving between the middle stages
  typedef struct packed {
    logic [63:0] value;
    logic [63:0] ref_ticks;
    status_t     status;
  } stage_t;

  // Word leaving the drift stage
  typedef struct packed {
    logic [63:0] cand;
    logic [63:0] abs_d;
    logic        ge;
    logic        dovf;
    status_t     status;
  } drift_t;

endpackage

### sv/tvt_ifs.sv
interface tvt_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] host_count;
  logic [63:0] ref_count;

  modport source (output valid, host_count, ref_count, input ready);
  modport sink (input valid, host_count, ref_count, output ready);
endinterface

interface tvt_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [63:0]        virt_count;
  logic signed [63:0] drift;

  modport source (output valid, status, virt_count, drift, input ready);
  modport sink (input valid, status, virt_count, drift, output ready);
endinterface

interface tvt_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/tvt_mul.sv
module tvt_mul
  import tvt_pkg::*;
(
  input  logic       clk,
  input  logic [1:0] en,
  input  cfg_t       cfg,
  input  stage_t     din,
  output stage_t     dout
);

  logic [63:0] p0, p1, p2, p3;
  logic [63:0] ref_q;
  status_t     st_q;
  logic [33:0] mid;
  logic [63:0] hi;
  stage_t      res;

  // Form the four 32x32 partial products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      p0    <= {32'd0, din.value[31:0]}  * {32'd0, cfg.rate_scale[31:0]};
      p1    <= {32'd0, din.value[31:0]}  * {32'd0, cfg.rate_scale[63:32]};
      p2    <= {32'd0, din.value[63:32]} * {32'd0, cfg.rate_scale[31:0]};
      p3    <= {32'd0, din.value[63:32]} * {32'd0, cfg.rate_scale[63:32]};
      ref_q <= din.ref_ticks;
      st_q  <= din.status;
    end
  end

  // Combine the partial products into bits 95..32, flag a wide high word
  always_comb begin
    mid = {2'd0, p0[63:32]} + {2'd0, p1[31:0]} + {2'd0, p2[31:0]};
    hi  = p3 + {32'd0, p1[63:32]} + {32'd0, p2[63:32]} + {62'd0, mid[33:32]};
    res.value     = {hi[31:0], mid[31:0]};
    res.ref_ticks = ref_q;
    res.status    = st_q;
    if (st_q == ST_OK && hi[63:32] != 32'd0) begin
      res.status = ST_OVERFLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dout <= res;
    end
  end

endmodule

### sv/tvt_post.sv
module tvt_post
  import tvt_pkg::*;
(
  input  logic       clk,
  input  logic [3:0] en,
  input  cfg_t       cfg,
  input  stage_t     din,
  output drift_t     dout
);

  stage_t      s4, s5, s6;
  stage_t      s4_next, s5_next, s6_next;
  drift_t      s7_next;
  logic [64:0] sum1, sum2;
  logic        below;
  logic [63:0] d_up, d_dn;

  // Add base virtual value, catch the carry
  always_comb begin
    sum1    = {1'b0, din.value} + {1'b0, cfg.base_virt};
    s4_next = din;
    s4_next.value = sum1[63:0];
    if (din.status == ST_OK && sum1[64]) begin
      s4_next.status = ST_OVERFLOW;
    end
  end

  // Add signed offset: positive fails on carry, negative fails on borrow
  always_comb begin
    sum2    = {1'b0, s4.value} + {1'b0, cfg.tick_offset};
    s5_next = s4;
    s5_next.value = sum2[63:0];
    if (s4.status == ST_OK && (cfg.tick_offset[63] ? !sum2[64] : sum2[64])) begin
      s5_next.status = ST_OVERFLOW;
    end
  end

  // Enforce the floor: clamp or reject
  always_comb begin
    below   = (cfg.floor_virt != 64'd0) && (s5.value < cfg.floor_virt);
    s6_next = s5;
    if (s5.status == ST_OK && below) begin
      if (cfg.mode_bits[MODE_CLAMP]) begin
        s6_next.value = cfg.floor_virt;
      end else begin
        s6_next.status = ST_NONMONO;
      end
    end
  end

  // Form drift magnitude and its sign
  always_comb begin
    d_up = s6.value - s6.ref_ticks;
    d_dn = s6.ref_ticks - s6.value;
    s7_next.cand   = s6.value;
    s7_next.ge     = s6.value >= s6.ref_ticks;
    s7_next.abs_d  = s7_next.ge ? d_up : d_dn;
    s7_next.dovf   = s7_next.ge ? s7_next.abs_d[63]
                                : (s7_next.abs_d[63] && s7_next.abs_d[62:0] != 63'd0);
    s7_next.status = s6.status;
  end

  always_ff @(posedge clk) begin
    if (en[0]) s4 <= s4_next;
    if (en[1]) s5 <= s5_next;
    if (en[2]) s6 <= s6_next;
    if (en[3]) dout <= s7_next;
  end

endmodule

### sv/tsc_virtual_time_transform_top.sv
// Pipeline: 8 register stages (s1, partial products, s3, s4, s5, s6, s7, output); a word
// accepted from sample passes through each in order and leaves when result is ready.
// Throughput: one sample per cycle while result is ready; the multiply is four 32x32 partial
// products in one stage, summed in the next, and no stage iterates.
// A stalled output holds its word; stages behind it keep loading until all hold words.
// Reset (rst, synchronous): all stage valid bits clear, config registers go to zero.
module tsc_virtual_time_transform_top
  import tvt_pkg::*;
(
  input logic     clk,
  input logic     rst,
  tvt_in_if.sink  sample,
  tvt_cfg_if.sink cfg,
  tvt_out_if.source result
);

  localparam int unsigned NSTG = 8;

  cfg_t              regs;
  logic [NSTG:1]     vld;
  logic [NSTG:1]     en;
  stage_t            s1, s1_next, s3;
  drift_t            s7;
  status_t           out_status;
  logic [63:0]       out_virtual;
  logic signed [63:0] out_drift;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_BASE_SOURCE:  regs.base_src       <= cfg.data;
        REG_BASE_VIRTUAL: regs.base_virt      <= cfg.data;
        REG_SCALE:        regs.rate_scale     <= cfg.data;
        REG_OFFSET:       regs.tick_offset    <= cfg.data;
        REG_FLOOR:        regs.floor_virt     <= cfg.data;
        REG_MAX_DRIFT:    regs.drift_limit    <= cfg.data;
        REG_MODE:         regs.mode_bits      <= cfg.data[MODE_W-1:0];
        REG_GENERATION:   regs.generation_tag <= cfg.data;
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en[NSTG] = !vld[NSTG] || result.ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign sample.ready = en[1];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= sample.valid;
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Early checks and offset from base
  always_comb begin
    s1_next.value     = sample.host_count - regs.base_src;
    s1_next.ref_ticks = sample.ref_count;
    if (regs.rate_scale == 64'd0 || regs.generation_tag == 64'd0) begin
      s1_next.status = ST_INVALID;
    end else if (regs.mode_bits[MODE_PAUSE]) begin
      s1_next.status = ST_PAUSED;
    end else if (sample.host_count < regs.base_src) begin
      s1_next.status = ST_NONMONO;
    end else begin
      s1_next.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) s1 <= s1_next;
  end

  tvt_mul u_mul (
    .clk  (clk),
    .en   (en[3:2]),
    .cfg  (regs),
    .din  (s1),
    .dout (s3)
  );

  tvt_post u_post (
    .clk  (clk),
    .en   (en[7:4]),
    .cfg  (regs),
    .din  (s3),
    .dout (s7)
  );

  // Final status, drop failed fields, sign the drift
  always_ff @(posedge clk) begin
    if (en[NSTG]) begin
      if (s7.status != ST_OK) begin
        out_status  <= s7.status;
        out_virtual <= 64'd0;
        out_drift   <= 64'sd0;
      end else if (s7.dovf) begin
        out_status  <= ST_OVERFLOW;
        out_virtual <= s7.cand;
        out_drift   <= 64'sd0;
      end else begin
        out_status  <= (s7.abs_d > regs.drift_limit) ? ST_DRIFT : ST_OK;
        out_virtual <= s7.cand;
        out_drift   <= s7.ge ? s7.abs_d : (~s7.abs_d + 64'd1);
      end
    end
  end

  assign result.valid      = vld[NSTG];
  assign result.status     = out_status;
  assign result.virt_count = out_virtual;
  assign result.drift      = out_drift;

`ifndef SYNTH
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> (&vld))
    else $error("input stalled with an empty stage");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status == ST_INVALID || result.status == ST_PAUSED ||
                     result.status == ST_NONMONO) |-> result.virt_count == 64'd0)
    else $error("failed projection carries a virtual value");

  a_drift_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != ST_OK && result.status != ST_DRIFT
      |-> result.drift == 64'sd0)
    else $error("drift present on a failed word");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.status <= ST_DRIFT)
    else $error("status code out of range");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    vld[NSTG-1] && !vld[NSTG] |=> vld[NSTG])
    else $error("word lost before the output stage");
`endif

endmodule
